[src/bgd_pkg.sv]
package bgd_pkg;

    // Gesture codes reported on the result stream
    typedef enum logic [2:0] {
        GEST_NONE      = 3'd0,
        GEST_SINGLE    = 3'd1,
        GEST_DOUBLE    = 3'd2,
        GEST_LONG      = 3'd3,
        GEST_VERY_LONG = 3'd4,
        GEST_FACTORY   = 3'd5
    } gesture_t;

    // Configuration register indexes
    localparam logic [2:0] REG_ACTIVE_LOW     = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE_TIME  = 3'd1;
    localparam logic [2:0] REG_SHORT_MAX_TIME = 3'd2;
    localparam logic [2:0] REG_LONG_MIN_TIME  = 3'd3;
    localparam logic [2:0] REG_VERY_LONG_TIME = 3'd4;
    localparam logic [2:0] REG_FACTORY_TIME   = 3'd5;
    localparam logic [2:0] REG_CLICK_GAP_TIME = 3'd6;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;
    localparam int InDataWidth   = 40;
    localparam int OutDataWidth  = 40;

    localparam logic [7:0] CLICK_MAX = 8'hFF;

    // Current configuration as seen by the tick logic
    typedef struct packed {
        logic        active_low;
        logic [15:0] debounce_time;
        logic [15:0] short_max_time;
        logic [15:0] long_min_time;
        logic [15:0] very_long_time;
        logic [15:0] factory_reset_time;
        logic [15:0] click_gap_time;
    } cfg_t;

    // One polling tick
    typedef struct packed {
        logic [31:0] now_ms;
        logic        pin_level;
    } tick_t;

    // One result item
    typedef struct packed {
        logic [31:0] hold_time;
        logic        is_pressed;
        gesture_t    gesture;
    } result_t;

endpackage

[src/button_gesture_debouncer_core.sv]
// Channel   Direction  Ports                         Payload
// s_axis    in         s_tvalid s_tready s_tdata     one polling tick
// m_axis    out        m_tvalid m_tready m_tdata     one result per tick
// cfg       in         cfg_wen cfg_index cfg_data    register write, no read-back
//
// One tick per clock sustained while m_tready is high; m_tvalid is registered.
// The tick sits in an input register, all gesture logic runs in one combinational
// pass into the output register, and the tracker state commits on that same edge.
// A stalled output holds its result while one more tick waits in the input register.
// Reset clears the tracker state, both valid flags and loads the default settings.
module button_gesture_debouncer_core
    import bgd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [InDataWidth-1:0]   s_tdata,   // [0] pin_level, [32:1] now_ms
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OutDataWidth-1:0]  m_tdata,   // [2:0] gesture, [3] is_pressed,
                                                // [35:4] hold_time
    input  logic                     cfg_wen,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t result;
    result_t result_reg;
    logic    advance;
    logic    accept;

    bgd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgd_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg),
        .tick    (tick_reg),
        .result  (result)
    );

    // Move a tick forward whenever the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg.pin_level <= s_tdata[0];
            tick_reg.now_ms    <= s_tdata[32:1];
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, result_reg.hold_time, result_reg.is_pressed,
                       result_reg.gesture};

endmodule

[src/bgd_cfg_regs.sv]
module bgd_cfg_regs
    import bgd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wen,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    // Write one register per transaction; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_low         <= 1'b1;
            cfg_reg.debounce_time      <= 16'd50;
            cfg_reg.short_max_time     <= 16'd500;
            cfg_reg.long_min_time      <= 16'd1000;
            cfg_reg.very_long_time     <= 16'd5000;
            cfg_reg.factory_reset_time <= 16'd10000;
            cfg_reg.click_gap_time     <= 16'd300;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ACTIVE_LOW:     cfg_reg.active_low         <= cfg_data[0];
                REG_DEBOUNCE_TIME:  cfg_reg.debounce_time      <= cfg_data;
                REG_SHORT_MAX_TIME: cfg_reg.short_max_time     <= cfg_data;
                REG_LONG_MIN_TIME:  cfg_reg.long_min_time      <= cfg_data;
                REG_VERY_LONG_TIME: cfg_reg.very_long_time     <= cfg_data;
                REG_FACTORY_TIME:   cfg_reg.factory_reset_time <= cfg_data;
                REG_CLICK_GAP_TIME: cfg_reg.click_gap_time     <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/bgd_tracker.sv]
module bgd_tracker
    import bgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  cfg_t    cfg,
    input  tick_t   tick,
    output result_t result
);

    logic        raw_seen_reg, raw_seen_next;
    logic        debounced_reg, debounced_next;
    logic [31:0] raw_change_reg, raw_change_next;
    logic [31:0] press_start_reg, press_start_next;
    logic [31:0] release_reg, release_next;
    logic [7:0]  clicks_reg, clicks_next;
    logic        long_done_reg, long_done_next;
    logic        very_long_done_reg, very_long_done_next;
    logic        factory_done_reg, factory_done_next;

    // Compute the next state and the result of the tick in the input register
    always_comb
    begin
        logic        raw;
        logic        fired;
        logic [31:0] since_change;
        logic [31:0] held_release;
        logic [31:0] held;
        logic [31:0] since_release;
        gesture_t    gesture;

        raw_seen_next       = raw_seen_reg;
        debounced_next      = debounced_reg;
        raw_change_next     = raw_change_reg;
        press_start_next    = press_start_reg;
        release_next        = release_reg;
        clicks_next         = clicks_reg;
        long_done_next      = long_done_reg;
        very_long_done_next = very_long_done_reg;
        factory_done_next   = factory_done_reg;
        gesture             = GEST_NONE;
        fired               = 1'b0;

        // Apply polarity and restart the settle timer on a raw change
        raw = cfg.active_low ? ~tick.pin_level : tick.pin_level;
        if (raw != raw_seen_reg)
        begin
            raw_change_next = tick.now_ms;
            raw_seen_next   = raw;
        end

        // Accept a settled level
        since_change = tick.now_ms - raw_change_next;
        held_release = tick.now_ms - press_start_reg;
        if (since_change >= {16'd0, cfg.debounce_time} && raw != debounced_reg)
        begin
            debounced_next = raw;
            if (raw)
            begin
                press_start_next    = tick.now_ms;
                long_done_next      = 1'b0;
                very_long_done_next = 1'b0;
                factory_done_next   = 1'b0;
            end
            else
            begin
                release_next = tick.now_ms;
                if (!long_done_reg && !very_long_done_reg && !factory_done_reg &&
                    held_release < {16'd0, cfg.short_max_time} && clicks_reg != CLICK_MAX)
                begin
                    clicks_next = clicks_reg + 8'd1;
                end
            end
        end

        // Hold gestures, factory reset first, then very long, then long
        held = tick.now_ms - press_start_next;
        if (debounced_next)
        begin
            if (held >= {16'd0, cfg.factory_reset_time} && !factory_done_next)
            begin
                factory_done_next = 1'b1;
                clicks_next       = 8'd0;
                gesture           = GEST_FACTORY;
                fired             = 1'b1;
            end
            else if (held >= {16'd0, cfg.very_long_time} &&
                     held < {16'd0, cfg.factory_reset_time} && !very_long_done_next)
            begin
                very_long_done_next = 1'b1;
                clicks_next         = 8'd0;
                gesture             = GEST_VERY_LONG;
                fired               = 1'b1;
            end
            else if (held >= {16'd0, cfg.long_min_time} &&
                     held < {16'd0, cfg.very_long_time} && !long_done_next)
            begin
                long_done_next = 1'b1;
                clicks_next    = 8'd0;
                gesture        = GEST_LONG;
                fired          = 1'b1;
            end
        end

        // Resolve clicks after the quiet gap
        since_release = tick.now_ms - release_next;
        if (!fired && !debounced_next && clicks_next != 8'd0 &&
            since_release >= {16'd0, cfg.click_gap_time})
        begin
            gesture     = (clicks_next == 8'd1) ? GEST_SINGLE : GEST_DOUBLE;
            clicks_next = 8'd0;
        end

        result.gesture    = gesture;
        result.is_pressed = debounced_next;
        result.hold_time  = (debounced_next && press_start_next != 32'd0) ? held : 32'd0;
    end

    // Commit the state when the tick moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_seen_reg       <= 1'b0;
            debounced_reg      <= 1'b0;
            raw_change_reg     <= 32'd0;
            press_start_reg    <= 32'd0;
            release_reg        <= 32'd0;
            clicks_reg         <= 8'd0;
            long_done_reg      <= 1'b0;
            very_long_done_reg <= 1'b0;
            factory_done_reg   <= 1'b0;
        end
        else if (advance)
        begin
            raw_seen_reg       <= raw_seen_next;
            debounced_reg      <= debounced_next;
            raw_change_reg     <= raw_change_next;
            press_start_reg    <= press_start_next;
            release_reg        <= release_next;
            clicks_reg         <= clicks_next;
            long_done_reg      <= long_done_next;
            very_long_done_reg <= very_long_done_next;
            factory_done_reg   <= factory_done_next;
        end
    end

endmodule

[tb/gesture_result_checker.sv]
`timescale 1ns / 1ps

// Watches the tick and result streams, predicts each result and compares.
module gesture_result_checker
    import bgd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [InDataWidth-1:0]   s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OutDataWidth-1:0]  m_tdata,
    input  logic                     cfg_wen,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output int                       fail_count,
    output int                       pending,
    output int                       results_checked,
    output int                       click_gestures,
    output int                       hold_gestures
);

    // Settings and tracker state as the block should hold them
    cfg_t        cfg;
    logic        raw_seen;
    logic        deb_pressed;
    logic [31:0] raw_change_ms;
    logic [31:0] press_start_ms;
    logic [31:0] release_ms;
    logic [7:0]  click_total;
    logic        long_done;
    logic        very_long_done;
    logic        factory_done;

    result_t     expected_results[$];

    // Advance the tracker by one tick and queue the result it yields
    task automatic predict_tick(input logic pin, input logic [31:0] now);
        logic        raw;
        logic [31:0] held;
        logic        fired;
        gesture_t    gest;
        result_t     res;
        raw   = cfg.active_low ? !pin : pin;
        gest  = GEST_NONE;
        fired = 1'b0;

        if (raw != raw_seen) begin
            raw_change_ms = now;
            raw_seen      = raw;
        end

        // Accept the level once it has been stable long enough
        if ((now - raw_change_ms) >= {16'd0, cfg.debounce_time} && raw != deb_pressed) begin
            deb_pressed = raw;
            if (deb_pressed) begin
                press_start_ms = now;
                long_done      = 1'b0;
                very_long_done = 1'b0;
                factory_done   = 1'b0;
            end
            else begin
                held       = now - press_start_ms;
                release_ms = now;
                if (!long_done && !very_long_done && !factory_done &&
                    held < {16'd0, cfg.short_max_time} && click_total < CLICK_MAX)
                    click_total = click_total + 8'd1;
            end
        end

        // Hold gestures, factory reset first
        if (deb_pressed) begin
            held = now - press_start_ms;
            if (held >= {16'd0, cfg.factory_reset_time} && !factory_done) begin
                factory_done = 1'b1;
                click_total  = 8'd0;
                gest         = GEST_FACTORY;
                fired        = 1'b1;
            end
            else if (held >= {16'd0, cfg.very_long_time} &&
                     held < {16'd0, cfg.factory_reset_time} && !very_long_done) begin
                very_long_done = 1'b1;
                click_total    = 8'd0;
                gest           = GEST_VERY_LONG;
                fired          = 1'b1;
            end
            else if (held >= {16'd0, cfg.long_min_time} &&
                     held < {16'd0, cfg.very_long_time} && !long_done) begin
                long_done   = 1'b1;
                click_total = 8'd0;
                gest        = GEST_LONG;
                fired       = 1'b1;
            end
        end

        // Resolve clicks after the quiet gap
        if (!fired && !deb_pressed && click_total != 8'd0 &&
            (now - release_ms) >= {16'd0, cfg.click_gap_time}) begin
            gest        = (click_total == 8'd1) ? GEST_SINGLE : GEST_DOUBLE;
            click_total = 8'd0;
        end

        if (gest == GEST_SINGLE || gest == GEST_DOUBLE)
            click_gestures++;
        else if (gest != GEST_NONE)
            hold_gestures++;

        res.gesture    = gest;
        res.is_pressed = deb_pressed;
        res.hold_time  = (deb_pressed && press_start_ms != 32'd0) ? now - press_start_ms : 32'd0;
        expected_results.push_back(res);
    endtask

    // Compare one delivered result against the oldest prediction
    task automatic check_result(input logic [OutDataWidth-1:0] data);
        result_t got;
        result_t exp_res;
        got = result_t'(data[$bits(result_t)-1:0]);
        results_checked++;
        if (expected_results.size() == 0) begin
            $error("result with no tick pending: gesture %0d is_pressed %0d hold_time %0d",
                   got.gesture, got.is_pressed, got.hold_time);
            fail_count++;
        end
        else begin
            exp_res = expected_results.pop_front();
            if (got.gesture != exp_res.gesture) begin
                $error("gesture expected %0d actual %0d", exp_res.gesture, got.gesture);
                fail_count++;
            end
            if (got.is_pressed != exp_res.is_pressed) begin
                $error("is_pressed expected %0d actual %0d", exp_res.is_pressed, got.is_pressed);
                fail_count++;
            end
            if (got.hold_time != exp_res.hold_time) begin
                $error("hold_time expected %0d actual %0d", exp_res.hold_time, got.hold_time);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg.active_low         = 1'b1;
            cfg.debounce_time      = 16'd50;
            cfg.short_max_time     = 16'd500;
            cfg.long_min_time      = 16'd1000;
            cfg.very_long_time     = 16'd5000;
            cfg.factory_reset_time = 16'd10000;
            cfg.click_gap_time     = 16'd300;
            raw_seen        = 1'b0;
            deb_pressed     = 1'b0;
            raw_change_ms   = 32'd0;
            press_start_ms  = 32'd0;
            release_ms      = 32'd0;
            click_total     = 8'd0;
            long_done       = 1'b0;
            very_long_done  = 1'b0;
            factory_done    = 1'b0;
            expected_results.delete();
            fail_count      = 0;
            pending         = 0;
            results_checked = 0;
            click_gestures  = 0;
            hold_gestures   = 0;
        end
        else begin
            // Track register writes; unknown indexes are dropped
            if (cfg_wen) begin
                case (cfg_index)
                    REG_ACTIVE_LOW:     cfg.active_low         = cfg_data[0];
                    REG_DEBOUNCE_TIME:  cfg.debounce_time      = cfg_data;
                    REG_SHORT_MAX_TIME: cfg.short_max_time     = cfg_data;
                    REG_LONG_MIN_TIME:  cfg.long_min_time      = cfg_data;
                    REG_VERY_LONG_TIME: cfg.very_long_time     = cfg_data;
                    REG_FACTORY_TIME:   cfg.factory_reset_time = cfg_data;
                    REG_CLICK_GAP_TIME: cfg.click_gap_time     = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                predict_tick(s_tdata[0], s_tdata[32:1]);
            pending = expected_results.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import bgd_pkg::*;

    // Index past the register list, written to show it is ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int PhaseTicks = 125;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [InDataWidth-1:0]   s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OutDataWidth-1:0]  m_tdata;
    logic                     cfg_wen = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int results_checked;
    int click_gestures;
    int hold_gestures;

    // Stimulus bookkeeping
    logic [31:0] now_t = 32'd0;
    logic        press_lvl = 1'b0;
    int          deb_ms = 50;
    int          short_ms = 500;
    int          long_ms = 1000;
    int          vlong_ms = 5000;
    int          fac_ms = 10000;
    int          gap_ms = 300;
    int          ticks_sent = 0;
    int          settings_used = 1;
    int          burst_left = 8;
    int          stall_mode = 0;
    int          stall_cnt = 0;

    button_gesture_debouncer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gesture_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .click_gestures  (click_gestures),
        .hold_gestures   (hold_gestures)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: switch between always ready, random and mostly stalled
    always @(negedge clk)
    begin
        if (stall_cnt == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt  = $urandom_range(16, 80);
        end
        else
        begin
            stall_cnt--;
        end
        case (stall_mode)
            0:       m_tready = 1'b1;
            1:       m_tready = 1'($urandom_range(0, 1));
            default: m_tready = ($urandom_range(0, 7) == 0);
        endcase
    end

    // Send one tick and hold it until accepted; insert gaps between bursts
    task automatic drive_tick(input logic pin, input logic [31:0] t);
        int gap;
        s_tdata  = {{(InDataWidth - 33){1'b0}}, t, pin};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        ticks_sent++;
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_wen   = 1'b0;
    endtask

    // Drain the block, then load a full set of registers
    task automatic apply_settings(input logic al, input int d, input int s, input int l,
                                  input int v, input int f, input int g);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        // upper bits of the polarity write are junk and must be masked off
        write_reg(REG_ACTIVE_LOW, {15'($urandom), al});
        write_reg(REG_DEBOUNCE_TIME, 16'(d));
        write_reg(REG_SHORT_MAX_TIME, 16'(s));
        write_reg(REG_LONG_MIN_TIME, 16'(l));
        write_reg(REG_VERY_LONG_TIME, 16'(v));
        write_reg(REG_FACTORY_TIME, 16'(f));
        write_reg(REG_CLICK_GAP_TIME, 16'(g));
        write_reg(REG_UNUSED, 16'($urandom));
        press_lvl = !al;
        deb_ms    = d;
        short_ms  = s;
        long_ms   = l;
        vlong_ms  = v;
        fac_ms    = f;
        gap_ms    = g;
        settings_used++;
    endtask

    // Hold a level for about dur ms over n ticks, sometimes with contact chatter first
    task automatic drive_level(input logic lvl, input int dur, input int n);
        int step;
        int k;
        if ($urandom_range(0, 3) == 0 && deb_ms > 2)
        begin
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++)
            begin
                now_t = now_t + 32'($urandom_range(0, deb_ms / 2));
                drive_tick(lvl, now_t);
                now_t = now_t + 32'($urandom_range(0, deb_ms / 2));
                drive_tick(!lvl, now_t);
            end
        end
        step = (n > 1) ? dur / (n - 1) : dur;
        for (int i = 0; i < n; i++)
        begin
            now_t = now_t + 32'((i == 0) ? $urandom_range(1, 20)
                                         : step + $urandom_range(0, step / 4 + 1));
            drive_tick(lvl, now_t);
        end
    endtask

    // Duration landing close to a hold threshold
    function automatic int near_ms(input int thr);
        int d;
        d = deb_ms + thr + $urandom_range(0, 200) - 100;
        return (d < deb_ms + 1) ? deb_ms + 1 : d;
    endfunction

    // Random gestures under the current settings until quota ticks are sent
    task automatic run_gestures(input int quota);
        int stop_at;
        int pick;
        int k;
        int dur;
        stop_at = ticks_sent + quota;
        while (ticks_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 92)
                now_t = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
            if (pick < 45 || pick >= 92)
            begin
                // one or more short presses, then a quiet gap
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++)
                begin
                    drive_level(press_lvl, deb_ms + ((short_ms > 0) ?
                                $urandom_range(0, short_ms) : $urandom_range(0, 5)),
                                $urandom_range(1, 4));
                    drive_level(!press_lvl, deb_ms + $urandom_range(0, gap_ms + 5),
                                $urandom_range(1, 3));
                end
                drive_level(!press_lvl, deb_ms + gap_ms + $urandom_range(1, 100),
                            $urandom_range(1, 3));
            end
            else if (pick < 80)
            begin
                // long hold around one of the thresholds
                case ($urandom_range(0, 3))
                    0:       dur = near_ms(long_ms);
                    1:       dur = near_ms(vlong_ms);
                    2:       dur = near_ms(fac_ms);
                    default: dur = deb_ms + fac_ms + $urandom_range(1, 3000);
                endcase
                drive_level(press_lvl, dur, $urandom_range(3, 12));
                drive_level(!press_lvl, deb_ms + gap_ms + $urandom_range(1, 200),
                            $urandom_range(1, 3));
            end
            else
            begin
                // noise: random levels and arbitrary time jumps
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        now_t = $urandom;
                    else
                        now_t = now_t + 32'($urandom_range(0, 2 * deb_ms + 10));
                    drive_tick(1'($urandom_range(0, 1)), now_t);
                end
            end
        end
    endtask

    // Hard limit on run time
    initial
    begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed ticks under reset settings (low pin means pressed)
        drive_tick(1'b1, 32'd0);
        // press that debounces exactly at time zero: hold_time stays 0
        drive_tick(1'b0, 32'hFFFF_FFCE);
        drive_tick(1'b0, 32'd0);
        drive_tick(1'b0, 32'd1000);
        drive_tick(1'b0, 32'd5000);
        drive_tick(1'b0, 32'd10000);
        drive_tick(1'b1, 32'd10010);
        drive_tick(1'b1, 32'd10060);
        // single click
        drive_tick(1'b0, 32'd11000);
        drive_tick(1'b0, 32'd11050);
        drive_tick(1'b1, 32'd11200);
        drive_tick(1'b1, 32'd11250);
        drive_tick(1'b1, 32'd11600);
        // double click
        drive_tick(1'b0, 32'd12000);
        drive_tick(1'b0, 32'd12050);
        drive_tick(1'b1, 32'd12100);
        drive_tick(1'b1, 32'd12150);
        drive_tick(1'b0, 32'd12200);
        drive_tick(1'b0, 32'd12250);
        drive_tick(1'b1, 32'd12300);
        drive_tick(1'b1, 32'd12350);
        drive_tick(1'b1, 32'd12700);
        // chatter shorter than the debounce time, then the top timestamp
        drive_tick(1'b0, 32'd13000);
        drive_tick(1'b1, 32'd13010);
        drive_tick(1'b1, 32'hFFFF_FFFF);
        now_t = 32'd20000;

        // Random phases over several register settings
        apply_settings(1'b0, 20, 400, 800, 2000, 3000, 150);
        run_gestures(PhaseTicks);
        apply_settings(1'b0, 0, 0, 0, 0, 0, 0);
        run_gestures(PhaseTicks);
        apply_settings(1'b1, 65535, 65535, 65535, 65535, 65535, 65535);
        run_gestures(PhaseTicks);
        // thresholds out of order
        apply_settings(1'b1, 10, 600, 3000, 1500, 800, 200);
        run_gestures(PhaseTicks);
        apply_settings(1'($urandom_range(0, 1)), $urandom_range(1, 100),
                       $urandom_range(100, 900),
                       $urandom_range(900, 2000), $urandom_range(2000, 6000),
                       $urandom_range(6000, 12000), $urandom_range(50, 600));
        run_gestures(PhaseTicks);
        apply_settings(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                       $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
        run_gestures(PhaseTicks);

        // Drain and let any stray result show up
        s_tvalid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d ticks under %0d register settings, %0d results compared",
                 ticks_sent, settings_used, results_checked);
        $display("click gestures %0d, hold gestures %0d", click_gestures, hold_gestures);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[files.f]
src/bgd_pkg.sv
src/bgd_cfg_regs.sv
src/bgd_tracker.sv
src/button_gesture_debouncer_core.sv
tb/gesture_result_checker.sv
tb/testbench.sv
